// ----- design/mips_subset_five_stage_pipeline_defines.svh -----
// assertion macros for the mips subset pipeline
// included by files that carry concurrent checks; no other dependencies
`ifndef MIPS_SUBSET_FIVE_STAGE_PIPELINE_DEFINES_SVH
`define MIPS_SUBSET_FIVE_STAGE_PIPELINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define MSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed in same cycle");

// consequent must hold in the cycle after the antecedent
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed in next cycle");

`else

`define MSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/msp_pkg.sv -----
// shared types, codes and sizes of the mips subset pipeline
// used by msp_alu, the top level, the checker and the testbench; no dependencies
package msp_pkg;

    // storage sizes
    localparam int MEM_AW = 8;
    localparam int REG_AW = 5;

    // item kinds carried in the input tuser
    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_TICK = 1'b1;

    // control words and their bits
    typedef logic [10:0] t_ctrl;
    localparam t_ctrl CTRL_NONE  = 11'h000;
    localparam t_ctrl CTRL_RTYPE = 11'h588;
    localparam t_ctrl CTRL_LW    = 11'h2C0;
    localparam t_ctrl CTRL_SW    = 11'h220;
    localparam t_ctrl CTRL_ADDI  = 11'h380;
    localparam int CB_REGDST = 10;
    localparam int CB_ALUSRC = 9;
    localparam int CB_MEMTOREG_N = 8;
    localparam int CB_REGWRITE = 7;
    localparam int CB_MEMREAD = 6;
    localparam int CB_MEMWRITE = 5;

    // opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_ADDI  = 6'h08;

    // r-type function codes
    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_HALT = 6'd12;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_SLT  = 6'd42;

    // halt and countdown
    localparam logic [31:0] HALT_WORD = 32'd12;
    localparam logic [9:0]  HALT_DRAIN = 10'd4;
    localparam logic [9:0]  COUNTDOWN_START = 10'd1000;
    localparam logic [31:0] RESET_PC = 32'd4;

    // pipeline latches
    typedef struct packed {
        logic [31:0] rd1;
        logic [31:0] rd2;
        logic [31:0] extnd;
        logic [4:0]  rt;
        logic [4:0]  rd;
        t_ctrl       ctrl;
    } t_de_latch;

    typedef struct packed {
        logic [31:0] alu;
        logic [31:0] rd2;
        logic [4:0]  regrd;
        t_ctrl       ctrl;
    } t_em_latch;

    typedef struct packed {
        logic [31:0] memout;
        logic [31:0] alu;
        logic [4:0]  regrd;
        t_ctrl       ctrl;
    } t_mw_latch;

endpackage

// ----- design/msp_ram.sv -----
// one write, two read memory with registered reads, write-first bypass
// and per-entry valid bits so unwritten entries read as zero; no dependencies
module msp_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_q_a, r_q_b, r_wdata;
    logic              r_vld_a, r_vld_b, r_hit_a, r_hit_b;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q_a <= r_mem[i_raddr_a];
        r_q_b <= r_mem[i_raddr_b];
        r_wdata <= i_wdata;
    end

    // valid bits and bypass flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_vld_a <= r_vld[i_raddr_a];
            r_vld_b <= r_vld[i_raddr_b];
            r_hit_a <= i_we && (i_waddr == i_raddr_a);
            r_hit_b <= i_we && (i_waddr == i_raddr_b);
        end
    end

    // read data: fresh write wins, unwritten reads zero
    assign o_rdata_a = r_hit_a ? r_wdata : (r_vld_a ? r_q_a : '0);
    assign o_rdata_b = r_hit_b ? r_wdata : (r_vld_b ? r_q_b : '0);

endmodule

// ----- design/msp_alu.sv -----
// execute stage alu of the mips subset pipeline
// depends on msp_pkg for the latch type and the function codes
module msp_alu (
    input  msp_pkg::t_de_latch i_de,
    input  logic [31:0]        i_prev_alu,
    output logic [31:0]        o_alu
);
    import msp_pkg::*;

    logic [31:0] opb;
    logic [5:0]  efn;

    // operand select and operation
    always_comb begin
        opb = i_de.ctrl[CB_ALUSRC] ? i_de.extnd : i_de.rd2;
        efn = i_de.extnd[5:0];
        o_alu = i_prev_alu;
        if (i_de.ctrl == CTRL_RTYPE) begin
            case (efn)
                FN_ADD:  o_alu = i_de.rd1 + opb;
                FN_SUB:  o_alu = i_de.rd1 - opb;
                FN_SLL:  o_alu = i_de.rd1 << opb[4:0];
                FN_SRL:  o_alu = i_de.rd1 >> opb[4:0];
                FN_SLT:  o_alu = {31'd0, $signed(i_de.rd1) < $signed(opb)};
                FN_HALT: o_alu = '0;
                default: o_alu = i_prev_alu;
            endcase
        end else if (i_de.ctrl inside {CTRL_LW, CTRL_SW, CTRL_ADDI}) begin
            o_alu = i_de.rd1 + opb;
        end
    end

endmodule

// ----- design/mips_subset_five_stage_pipeline.sv -----
// top level of the mips subset five-stage pipeline
// depends on msp_pkg, msp_ram, msp_alu and the assertion macro header
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  load word or clock tick
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  pc, reg write, mem write, halted
//  cfg       in   i_cfg_valid/o_cfg_ready          start pc, loads the pc at once
//
// every accepted word is handled in the cycle it is taken; its result sits in
// the output register on the next cycle, one word per cycle sustained.
// memory and register reads are prefetched from next-state addresses,
// each ram port giving one read a cycle.
// reset sets all state but output data; valid bits stand in for zeroed memories.
// input is stalled only while a result waits and the output is stalled.
`include "mips_subset_five_stage_pipeline_defines.svh"

module mips_subset_five_stage_pipeline (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input words
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,  // load_addr[7:0], load_data[39:8]
    input  logic [0:0]   i_s_axis_tuser,  // operation[0]
    // result words
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pc_value[31:0], reg_number[36:32], reg_value[68:37], mem_word[76:69],
    // mem_value[108:77], halted[109], zero[111:110]
    output logic [111:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,  // reg_write_valid[0], mem_write_valid[1]
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [10:0]  i_cfg_data
);
    import msp_pkg::*;

    // state
    logic [31:0]  r_pc, n_pc;
    logic [31:0]  r_fd, n_fd;
    t_de_latch    r_de, n_de;
    t_em_latch    r_em, n_em;
    t_mw_latch    r_mw, n_mw;
    t_ctrl        r_ctrl, n_ctrl;
    logic [9:0]   r_cnt, n_cnt;
    logic         r_out_valid;
    logic [111:0] r_out_data;
    logic [1:0]   r_out_user;

    // handshake and per-word control
    logic s_acc, cfg_acc, is_load, tick_act;
    logic [31:0] fetched, mem_rd_b, rf_rd_a, rf_rd_b, alu_res, wd;
    logic [5:0]  op;
    logic        cur_shift;
    logic        mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [31:0] mem_wdata;
    logic [REG_AW-1:0] rf_raddr_a, rf_raddr_b;
    logic        wv, mv;
    logic [4:0]  wn;
    logic [MEM_AW-1:0] mw;

    function automatic logic f_is_shift(input logic [31:0] w);
        return (w[31:26] == OP_RTYPE) && (w[5:0] inside {FN_SLL, FN_SRL});
    endfunction

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign is_load = (i_s_axis_tuser[0] == OPER_LOAD);
    assign tick_act = s_acc && !is_load && (r_cnt != '0);

    // shared instruction and data memory: port a fetch, port b load read
    msp_ram #(.ADDR_W(MEM_AW), .DATA_W(32)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (fetched),
        .o_rdata_b (mem_rd_b)
    );

    // register file: reads for the word now in the fetch latch
    msp_ram #(.ADDR_W(REG_AW), .DATA_W(32)) u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wv),
        .i_waddr   (wn),
        .i_wdata   (wd),
        .i_raddr_a (rf_raddr_a),
        .i_raddr_b (rf_raddr_b),
        .o_rdata_a (rf_rd_a),
        .o_rdata_b (rf_rd_b)
    );

    // execute stage
    msp_alu u_alu (
        .i_de       (r_de),
        .i_prev_alu (r_em.alu),
        .o_alu      (alu_res)
    );

    // decode of the fetch latch
    always_comb begin
        op = r_fd[31:26];
        cur_shift = f_is_shift(r_fd);
        case (op)
            OP_RTYPE: n_ctrl = CTRL_RTYPE;
            OP_LW:    n_ctrl = CTRL_LW;
            OP_SW:    n_ctrl = CTRL_SW;
            OP_ADDI:  n_ctrl = CTRL_ADDI;
            default:  n_ctrl = r_ctrl;
        endcase
        n_de.rd1   = rf_rd_a;
        n_de.rd2   = cur_shift ? {27'd0, r_fd[10:6]} : rf_rd_b;
        n_de.extnd = {{16{r_fd[15]}}, r_fd[15:0]};
        n_de.rt    = r_fd[20:16];
        n_de.rd    = r_fd[15:11];
        n_de.ctrl  = n_ctrl;
    end

    // execute and memory latch contents
    always_comb begin
        n_em.alu   = alu_res;
        n_em.rd2   = r_de.rd2;
        n_em.regrd = r_de.ctrl[CB_REGDST] ? r_de.rd : r_de.rt;
        n_em.ctrl  = r_de.ctrl;
        n_mw.memout = r_em.ctrl[CB_MEMREAD] ? mem_rd_b : r_mw.memout;
        n_mw.alu    = r_em.alu;
        n_mw.regrd  = r_em.regrd;
        n_mw.ctrl   = r_em.ctrl;
    end

    // writeback and store of this tick
    assign wd = r_mw.ctrl[CB_MEMTOREG_N] ? r_mw.alu : r_mw.memout;
    assign wv = tick_act && r_mw.ctrl[CB_REGWRITE] && (r_mw.regrd != '0);
    assign wn = wv ? r_mw.regrd : '0;
    assign mv = tick_act && r_em.ctrl[CB_MEMWRITE];
    assign mw = mv ? r_em.alu[MEM_AW+1:2] : '0;

    // memory write port: load word or store
    always_comb begin
        mem_we    = s_acc && (is_load || mv);
        mem_waddr = is_load ? i_s_axis_tdata[7:0] : r_em.alu[MEM_AW+1:2];
        mem_wdata = is_load ? i_s_axis_tdata[39:8] : r_em.rd2;
    end

    // next pc, fetch latch and countdown
    always_comb begin
        if (cfg_acc) begin
            n_pc = {21'd0, i_cfg_data};
        end else if (tick_act) begin
            n_pc = r_pc + 32'd4;
        end else begin
            n_pc = r_pc;
        end
        n_fd = tick_act ? fetched : r_fd;
        if (tick_act) begin
            n_cnt = ((fetched == HALT_WORD) ? HALT_DRAIN : r_cnt) - 10'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // prefetch addresses taken from next state
    always_comb begin
        mem_raddr_a = n_pc[MEM_AW+1:2] - MEM_AW'(1);
        mem_raddr_b = tick_act ? n_em.alu[MEM_AW+1:2] : r_em.alu[MEM_AW+1:2];
        rf_raddr_a  = f_is_shift(n_fd) ? n_fd[20:16] : n_fd[25:21];
        rf_raddr_b  = n_fd[20:16];
    end

    // pipeline state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= RESET_PC;
            r_fd   <= '0;
            r_de   <= '0;
            r_em   <= '0;
            r_mw   <= '0;
            r_ctrl <= CTRL_NONE;
            r_cnt  <= COUNTDOWN_START;
        end else begin
            r_pc  <= n_pc;
            r_fd  <= n_fd;
            r_cnt <= n_cnt;
            if (tick_act) begin
                r_de   <= n_de;
                r_em   <= n_em;
                r_mw   <= n_mw;
                r_ctrl <= n_ctrl;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_data <= {2'b00, (n_cnt == '0), (mv ? r_em.rd2 : 32'd0), mw,
                           (wv ? wd : 32'd0), wn, n_pc};
            r_out_user <= {mv, wv};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // checks
    `MSP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, s_acc, o_m_axis_tvalid)
    `MSP_ASSERT_NEXT(a_halt_freezes_pc, i_clk, i_rst_n,
        s_acc && !is_load && (r_cnt == '0) && !cfg_acc, r_pc == $past(r_pc))
    `MSP_ASSERT_NEXT(a_tick_steps_pc, i_clk, i_rst_n,
        tick_act && !cfg_acc, r_pc == $past(r_pc) + 32'd4)
    `MSP_ASSERT_NOW(a_no_write_to_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[36:32] != 5'd0)

endmodule

// ----- verif/msp_tick_checker.sv -----
// result checker for the mips subset pipeline: mirrors the pipeline state and
// compares every result word against its own prediction
// depends on msp_pkg for the latch types, control words and codes
module msp_tick_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [39:0]  i_s_data,   // load_addr[7:0], load_data[39:8]
    input  logic [0:0]   i_s_user,   // operation[0]
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [111:0] i_m_data,   // pc, reg_number, reg_value, mem_word, mem_value, halted
    input  logic [1:0]   i_m_user,   // reg_write_valid[0], mem_write_valid[1]
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [10:0]  i_cfg_data,
    output int           o_mismatches,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import msp_pkg::*;

    typedef struct packed {
        logic [31:0] pc;
        logic        reg_we;
        logic [4:0]  reg_num;
        logic [31:0] reg_val;
        logic        mem_we;
        logic [7:0]  mem_idx;
        logic [31:0] mem_val;
        logic        halted;
    } t_tick_report;

    // mirrored pipeline state
    logic [31:0]  gpr [2**REG_AW];
    logic [31:0]  ram [2**MEM_AW];
    logic [31:0]  pc_q;
    logic [31:0]  fd_q;
    t_de_latch    de_q;
    t_em_latch    em_q;
    t_mw_latch    mw_q;
    t_ctrl        dec_ctrl;
    logic [9:0]   countdown;

    t_tick_report expected_reports [$];
    int           mismatches = 0;

    task automatic log_mismatch(input string why, input t_tick_report w,
                                input t_tick_report g);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %0d, %s", mismatches, why);
            $display("  expected pc=%h rw=%b r%0d=%h mw=%b m[%h]=%h halted=%b",
                     w.pc, w.reg_we, w.reg_num, w.reg_val, w.mem_we, w.mem_idx,
                     w.mem_val, w.halted);
            $display("  actual   pc=%h rw=%b r%0d=%h mw=%b m[%h]=%h halted=%b",
                     g.pc, g.reg_we, g.reg_num, g.reg_val, g.mem_we, g.mem_idx,
                     g.mem_val, g.halted);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_tick_report want, got, rep;
        t_de_latch    ex, nd;
        t_em_latch    mm, ne;
        t_mw_latch    wb, nm;
        logic [31:0]  fetched, inst, imm, b, alu, wd, fpos;
        logic [5:0]   opc, fn, efn;
        logic [4:0]   rs, rt, rd, shamt;

        if (!i_rst_n) begin
            for (int k = 0; k < 2**REG_AW; k++) gpr[k] = '0;
            for (int k = 0; k < 2**MEM_AW; k++) ram[k] = '0;
            pc_q = RESET_PC;
            fd_q = '0;
            de_q = '0;
            em_q = '0;
            mw_q = '0;
            dec_ctrl = CTRL_NONE;
            countdown = COUNTDOWN_START;
            expected_reports.delete();
        end else begin
            // result word against the oldest prediction
            if (i_m_valid && i_m_ready) begin
                got.pc = i_m_data[31:0];
                got.reg_we = i_m_user[0];
                got.reg_num = i_m_data[36:32];
                got.reg_val = i_m_data[68:37];
                got.mem_we = i_m_user[1];
                got.mem_idx = i_m_data[76:69];
                got.mem_val = i_m_data[108:77];
                got.halted = i_m_data[109];
                if (expected_reports.size() == 0) begin
                    log_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (want != got) log_mismatch("field differs", want, got);
                end
            end

            // start pc write also reloads the pc
            if (i_cfg_valid && i_cfg_ready) begin
                pc_q = 32'(i_cfg_data);
            end

            // input word: predict its report
            if (i_s_valid && i_s_ready) begin
                rep = '0;
                if (i_s_user[0] == OPER_LOAD) begin
                    ram[i_s_data[7:0]] = i_s_data[39:8];
                end else if (countdown != '0) begin
                    ex = de_q;
                    mm = em_q;
                    wb = mw_q;

                    // fetch, one word below pc/4, wrapped
                    fpos = (pc_q >> 2) - 32'd1;
                    fetched = ram[fpos[MEM_AW-1:0]];

                    // decode; an unknown opcode leaves the control word alone
                    inst = fd_q;
                    opc = inst[31:26];
                    rs = inst[25:21];
                    rt = inst[20:16];
                    rd = inst[15:11];
                    shamt = inst[10:6];
                    fn = inst[5:0];
                    imm = {{16{inst[15]}}, inst[15:0]};
                    case (opc)
                        OP_RTYPE: dec_ctrl = CTRL_RTYPE;
                        OP_LW:    dec_ctrl = CTRL_LW;
                        OP_SW:    dec_ctrl = CTRL_SW;
                        OP_ADDI:  dec_ctrl = CTRL_ADDI;
                        default: ;
                    endcase
                    if (opc == OP_RTYPE && (fn == FN_SLL || fn == FN_SRL)) begin
                        nd.rd1 = gpr[rt];
                        nd.rd2 = 32'(shamt);
                    end else begin
                        nd.rd1 = gpr[rs];
                        nd.rd2 = gpr[rt];
                    end
                    nd.extnd = imm;
                    nd.rt = rt;
                    nd.rd = rd;
                    nd.ctrl = dec_ctrl;

                    // execute; alu holds its value for unknown functions
                    efn = ex.extnd[5:0];
                    b = ex.ctrl[CB_ALUSRC] ? ex.extnd : ex.rd2;
                    alu = mm.alu;
                    if (ex.ctrl == CTRL_RTYPE) begin
                        case (efn)
                            FN_ADD:  alu = ex.rd1 + b;
                            FN_SUB:  alu = ex.rd1 - b;
                            FN_SLL:  alu = ex.rd1 << b[4:0];
                            FN_SRL:  alu = ex.rd1 >> b[4:0];
                            FN_SLT:  alu = ($signed(ex.rd1) < $signed(b)) ? 32'd1 : 32'd0;
                            FN_HALT: alu = '0;
                            default: ;
                        endcase
                    end else if (ex.ctrl == CTRL_LW || ex.ctrl == CTRL_SW
                                 || ex.ctrl == CTRL_ADDI) begin
                        alu = ex.rd1 + b;
                    end
                    ne.alu = alu;
                    ne.rd2 = ex.rd2;
                    ne.ctrl = ex.ctrl;
                    ne.regrd = ex.ctrl[CB_REGDST] ? ex.rd : ex.rt;

                    // memory read sees the memory from before this tick
                    nm.memout = mm.ctrl[CB_MEMREAD] ? ram[mm.alu[MEM_AW+1:2]] : wb.memout;
                    nm.alu = mm.alu;
                    nm.regrd = mm.regrd;
                    nm.ctrl = mm.ctrl;

                    wd = wb.ctrl[CB_MEMTOREG_N] ? wb.alu : wb.memout;

                    // state updates
                    pc_q = pc_q + 32'd4;
                    if (mm.ctrl[CB_MEMWRITE]) begin
                        ram[mm.alu[MEM_AW+1:2]] = mm.rd2;
                        rep.mem_we = 1'b1;
                        rep.mem_idx = mm.alu[9:2];
                        rep.mem_val = mm.rd2;
                    end
                    // register zero swallows writes
                    if (wb.ctrl[CB_REGWRITE] && wb.regrd != '0) begin
                        gpr[wb.regrd] = wd;
                        rep.reg_we = 1'b1;
                        rep.reg_num = wb.regrd;
                        rep.reg_val = wd;
                    end
                    fd_q = fetched;
                    de_q = nd;
                    em_q = ne;
                    mw_q = nm;

                    if (fetched == HALT_WORD) countdown = HALT_DRAIN;
                    if (countdown != '0) countdown = countdown - 10'd1;
                end
                rep.pc = pc_q;
                rep.halted = (countdown == '0);
                expected_reports.push_back(rep);
            end
        end
        o_pending <= expected_reports.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- verif/testbench.sv -----
// top of the mips subset pipeline bench: clock, reset, stimulus and verdict
// depends on msp_pkg, the pipeline top level and msp_tick_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import msp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS = 1060;
    localparam int TICK_BUDGET = 900;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [39:0]  s_data;     // load_addr[7:0], load_data[39:8]
    logic [0:0]   s_user;     // operation[0]
    logic         m_valid;
    logic         m_ready = 1'b1;
    logic [111:0] m_data;     // pc, reg_number, reg_value, mem_word, mem_value, halted
    logic [1:0]   m_user;     // reg_write_valid[0], mem_write_valid[1]
    logic         cfg_valid;
    logic         cfg_ready;
    logic [10:0]  cfg_data;
    int           mismatches;
    int           pending;

    int           idle_cycles = 0;
    int           rx_left = 0;
    logic         rx_state = 1'b1;
    logic         calm = 1'b0;
    logic [31:0]  shadow_pc = RESET_PC;
    int           ticks_run = 0;
    int           items_sent = 0;

    mips_subset_five_stage_pipeline DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    msp_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, sh,
                                          input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                          input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // half the picks from a few registers so that results get reused
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 1) != 0) return 5'($urandom_range(0, 7));
        return 5'($urandom);
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    // one instruction word; the halt word is kept for the end of the run
    function automatic logic [31:0] make_instr();
        logic [31:0] w;
        logic [5:0]  fn;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 45) begin
            case ($urandom_range(0, 6))
                0: fn = FN_ADD;
                1: fn = FN_SUB;
                2: fn = FN_SLL;
                3: fn = FN_SRL;
                4: fn = FN_SLT;
                5: fn = FN_HALT;
                default: fn = 6'($urandom);
            endcase
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), fn);
        end else if (k < 60) begin
            w = enc_i(OP_ADDI, pick_reg(), pick_reg(), pick_imm());
        end else if (k < 74) begin
            w = enc_i(OP_LW, pick_reg(), pick_reg(), pick_imm());
        end else if (k < 88) begin
            w = enc_i(OP_SW, pick_reg(), pick_reg(), pick_imm());
        end else if (k < 95) begin
            w = $urandom;
        end else begin
            w = '0;
        end
        if (w == HALT_WORD) w[0] = 1'b1;
        return w;
    endfunction

    function automatic logic [31:0] make_data();
        logic [31:0] d;
        case ($urandom_range(0, 5))
            0: d = '0;
            1: d = '1;
            2: d = 32'($urandom_range(0, 1023));
            default: d = $urandom;
        endcase
        if (d == HALT_WORD) d[0] = 1'b1;
        return d;
    endfunction

    // memory word that the next tick fetches
    function automatic logic [7:0] fetch_index();
        logic [31:0] t;
        t = (shadow_pc >> 2) - 32'd1;
        return t[7:0];
    endfunction

    task automatic send_word(input logic op, input logic [7:0] addr, input logic [31:0] data);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {data, addr};
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic load(input logic [7:0] addr, input logic [31:0] data);
        send_word(OPER_LOAD, addr, data);
    endtask

    task automatic tick();
        send_word(OPER_TICK, 8'($urandom), $urandom);
        shadow_pc = shadow_pc + 32'd4;
        ticks_run++;
    endtask

    // stop sending until every result word is back, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_start_pc(input logic [10:0] v);
        drain();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        shadow_pc = 32'(v);
    endtask

    // load a program where the pc will fetch it, with stray data loads, then run it
    task automatic run_program(input int n_words);
        logic [7:0] base;
        base = fetch_index();
        for (int j = 0; j < n_words; j++) begin
            load(base + 8'(j), make_instr());
            if ($urandom_range(0, 9) == 0) load(8'($urandom), make_data());
        end
        for (int j = 0; j < n_words; j++) begin
            tick();
            if ($urandom_range(0, 11) == 0) load(8'($urandom), make_data());
        end
    endtask

    // result side: ready runs broken by stalls
    always @(negedge i_clk) begin : receiver
        int stall;
        if (rx_left > 0) begin
            rx_left--;
        end else if (rx_state) begin
            stall = gap_len();
            if (stall > 0) begin
                rx_state = 1'b0;
                rx_left = stall - 1;
            end else begin
                rx_left = $urandom_range(0, 24);
            end
        end else begin
            rx_state = 1'b1;
            rx_left = $urandom_range(0, 24);
        end
        m_ready <= rx_state;
    end

    // watchdog on cycles where no channel moves a word
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] directed [13];
        logic [7:0]  base;

        s_valid = 1'b0;
        s_data = '0;
        s_user = OPER_LOAD;
        cfg_valid = 1'b0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every operation, immediate extremes, full shifts, r0 writes,
        // an unknown opcode and a store that wraps around memory
        directed = '{
            enc_i(OP_ADDI, 5'd0, 5'd1, 16'hFFFF),
            enc_i(OP_ADDI, 5'd0, 5'd2, 16'h7FFF),
            enc_i(OP_ADDI, 5'd0, 5'd3, 16'h8000),
            32'h0000_0000,
            32'hFFFF_FFFF,
            enc_r(5'd1, 5'd2, 5'd4, 5'd0, FN_ADD),
            enc_r(5'd3, 5'd2, 5'd5, 5'd0, FN_SUB),
            enc_r(5'd0, 5'd1, 5'd6, 5'd31, FN_SLL),
            enc_r(5'd0, 5'd1, 5'd7, 5'd31, FN_SRL),
            enc_r(5'd1, 5'd2, 5'd8, 5'd0, FN_SLT),
            enc_i(OP_SW, 5'd1, 5'd2, 16'h7FFF),
            enc_i(OP_LW, 5'd0, 5'd9, 16'h8000),
            enc_r(5'd1, 5'd2, 5'd0, 5'd0, FN_HALT)
        };

        // start pc 1024: fetch begins at the last word and wraps to zero
        set_start_pc(11'd1024);
        base = fetch_index();
        for (int j = 0; j < 13; j++) load(base + 8'(j), directed[j]);
        repeat (13) tick();
        set_start_pc(11'd4);

        // random programs, with pc moves and pauses between them
        while (items_sent < TARGET_ITEMS && ticks_run < TICK_BUDGET) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: set_start_pc(11'($urandom_range(4, 1024)));
                1: set_start_pc(($urandom_range(0, 1) != 0) ? 11'd4 : 11'd1024);
                2: drain();
                default: ;
            endcase
            run_program($urandom_range(4, 20));
        end

        // halt word fetched: drain, then ticks and loads while halted
        calm = 1'b0;
        base = fetch_index();
        load(base, make_instr());
        load(base + 8'd1, HALT_WORD);
        repeat (8) tick();
        load(8'($urandom), make_data());
        load(8'($urandom), make_data());
        repeat (2) tick();

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
